// ===== sv/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distinct color collector package
// Beat types and fixed field widths for the collector; the table shares COLOR_W.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;
	localparam int COLOR_W             = 32;
	localparam int SLOT_W              = 8;
	localparam int COUNT_W             = 9;
	localparam int MAX_W               = 9;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               first_of_image;
		logic               last_of_image;
	} pixel_t;

	typedef struct packed {
		logic               is_new;
		logic [SLOT_W-1:0]  color_slot;
		logic [COUNT_W-1:0] distinct_count;
		logic               limit_reached;
		logic               overflow;
		logic               image_done;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/distinct_color_collector.sv =====
// ----------------------------------------------------------------------------
// Distinct color collector
// Builds the palette of distinct pixel colors in order of first appearance.
// ----------------------------------------------------------------------------
// A pixel beat is taken at a rising edge with start high and busy low. Each
// pixel produces exactly one result beat, shown for one cycle with
// result_valid high; the receiver cannot stall it.
// The pixel color is compared against the stored colors, one table entry
// per cycle through the registered read port of the color memory. A pixel
// whose color is new is written after the scan has passed every stored
// entry; a pixel that matches slot k ends the scan at that hit; once the
// limit is reached a pixel is not searched and gets its result in the
// cycle after accept. No new pixel is taken while the scan runs. Busy
// drops in the cycle the result is shown, so the next pixel can be taken
// at the edge that ends it.
// A first-of-image pixel empties the table (count and flags clear at once,
// the memory itself is not cleared). Reset clears the count, the flags,
// max_colors and the result strobe; the memory holds no reset value. The user
// must write max_colors via cfg_we/cfg_data only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_color_collector #(
	parameter int TABLE_DEPTH = dcc_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire dcc_pkg::pixel_t             pixel,
	output logic                             result_valid,
	output dcc_pkg::result_t                 result,
	input  wire logic                        cfg_we,
	input  wire logic [dcc_pkg::MAX_W-1:0]   cfg_data
);
	import dcc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > MAX_W) ? CW : MAX_W;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic               pend_q;
	logic               limit_q;
	logic               ovf_q;
	logic [MAX_W-1:0]   max_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;

	logic [COLOR_W-1:0] rdata;
	logic               hit;
	logic               more;
	logic               issue;
	logic               finish;
	logic               full;
	logic               add;
	logic [CW-1:0]      count_inc;
	logic [CW+SLOT_W-1:0]  slot_ext;
	logic [CW+COUNT_W-1:0] count_ext;
	logic [CW+COUNT_W-1:0] inc_ext;
	logic [LW-1:0]      inc_cmp;
	logic [LW-1:0]      max_cmp;
	logic               hits_limit;
	logic               accept;
	logic               limit_eff;

	assign accept    = start && (state_q == ST_IDLE);
	assign limit_eff = limit_q && !pixel.first_of_image;

	always_comb begin
		hit        = pend_q && (rdata == color_q);
		more       = idx_q < count_q;
		issue      = (state_q == ST_SEARCH) && !hit && more;
		finish     = (state_q == ST_SEARCH) && (hit || !more);
		full       = count_q == CW'(TABLE_DEPTH);
		add        = finish && !hit && !full;
		count_inc  = count_q + CW'(1);
		slot_ext   = {{SLOT_W{1'b0}}, count_q};
		count_ext  = {{COUNT_W{1'b0}}, count_q};
		inc_ext    = {{COUNT_W{1'b0}}, count_inc};
		inc_cmp    = LW'({{LW{1'b0}}, count_inc});
		max_cmp    = LW'({{LW{1'b0}}, max_q});
		hits_limit = (max_q != '0) && (inc_cmp >= max_cmp);
	end

	// A write lands only at the end of a pixel and the next scan starts only
	// once a new pixel is accepted, so reads never overlap a pending write.
	dcc_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (add),
		.waddr(count_q[AW-1:0]),
		.wdata(color_q),
		.re   (issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			limit_q      <= 1'b0;
			ovf_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						color_q <= pixel.pixel_color;
						last_q  <= pixel.last_of_image;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						if (pixel.first_of_image) begin
							count_q <= '0;
							limit_q <= 1'b0;
							ovf_q   <= 1'b0;
						end
						if (limit_eff) begin
							// Limit already reached: the pixel is not searched.
							result_valid          <= 1'b1;
							result.is_new         <= 1'b0;
							result.color_slot     <= '0;
							result.distinct_count <= count_ext[COUNT_W-1:0];
							result.limit_reached  <= 1'b1;
							result.overflow       <= ovf_q;
							result.image_done     <= pixel.last_of_image;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (finish) begin
						state_q               <= ST_IDLE;
						result_valid          <= 1'b1;
						result.is_new         <= add;
						result.color_slot     <= add ? slot_ext[SLOT_W-1:0] : '0;
						result.distinct_count <= add ? inc_ext[COUNT_W-1:0]
						                             : count_ext[COUNT_W-1:0];
						result.limit_reached  <= limit_q || (add && hits_limit);
						result.overflow       <= ovf_q || (!hit && full);
						result.image_done     <= last_q;
						if (add) begin
							count_q <= count_inc;
							if (hits_limit) begin
								limit_q <= 1'b1;
							end
						end else if (!hit) begin
							ovf_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// The scan only ever ends by reporting a result.
	a_fall_reports: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result beat");

	// Every accepted pixel either starts a scan or reports at once.
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || result_valid))
		else $error("accepted pixel neither searched nor reported");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("stored count beyond table depth");

	// Overflow can only be set by a full table and clears together with it.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CW'(TABLE_DEPTH)))
		else $error("overflow flag set while table not full");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q < count_q))
		else $error("table read beyond stored colors");

endmodule

`default_nettype wire

// ===== sv/dcc_table.sv =====
// ----------------------------------------------------------------------------
// Color table memory
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_table #(
	parameter int TABLE_DEPTH = dcc_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
	input  wire logic [dcc_pkg::COLOR_W-1:0]    wdata,
	input  wire logic                           re,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr,
	output logic      [dcc_pkg::COLOR_W-1:0]    rdata
);
	import dcc_pkg::*;

	logic [COLOR_W-1:0] mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
